### design/gcdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdd_pkg: shared types for the cycle deadlock detector
// Beat payloads, controller states, datapath ops and control/status bundles.
// ----------------------------------------------------------------------------
package gcdd_pkg;

  // fixed width of node fields on the ports
  localparam int unsigned NODE_W = 4;

  // input beat: one edge write
  typedef struct packed {
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic              edge_present;
  } req_t;

  // result beat
  typedef struct packed {
    logic              cycle_found;
    logic [NODE_W-1:0] back_from;
    logic [NODE_W-1:0] back_to;
  } res_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDIT_RD,
    ST_EDIT_WR,
    ST_ROOT,
    ST_FETCH,
    ST_SCAN,
    ST_POP_WAIT,
    ST_FINISH
  } ctrl_state_e;

  // one datapath operation per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ADJ_WRITE,
    OP_ROOT_NEXT,
    OP_ROOT_ENTER,
    OP_SKIP,
    OP_PUSH,
    OP_POP,
    OP_RESTORE,
    OP_HIT
  } dp_op_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e op;
    logic   adj_sel_from;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic root_end;
    logic root_visited;
    logic v_end;
    logic edge_hit;
    logic v_on_path;
    logic v_unvisited;
    logic depth_full;
    logic depth_one;
  } status_t;

endpackage

### design/gcdd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdd_ram: generic single-write, single-read memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gcdd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/gcdd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdd_datapath: graph storage and depth-first search datapath
// Adjacency memory with per-row valid flags, node color flags, path stack
// memory, scan pointers and the result registers.
// ----------------------------------------------------------------------------
module gcdd_datapath #(
  parameter int unsigned NODES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gcdd_pkg::req_t   req_i,
  input  gcdd_pkg::cmd_t   cmd_i,
  output gcdd_pkg::status_t status_o,
  output gcdd_pkg::res_t   res_o
);
  import gcdd_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned VW = $clog2(NODES + 1);
  localparam int unsigned SW = NW + VW;

  // latched edge write
  req_t req_q, req_d;

  // search state
  logic [NW-1:0]    cur_u_q, cur_u_d;
  logic [VW-1:0]    cur_v_q, cur_v_d;
  logic [VW-1:0]    depth_q, depth_d;
  logic [VW-1:0]    root_q, root_d;
  logic [NODES-1:0] on_path_q, on_path_d;
  logic [NODES-1:0] done_q, done_d;
  logic [NODES-1:0] row_valid_q, row_valid_d;
  logic             rvalid_q;
  logic             found_q, found_d;
  logic [NODE_W-1:0] bf_q, bf_d;
  logic [NODE_W-1:0] bt_q, bt_d;

  // memory ports
  logic [NW-1:0]    adj_raddr;
  logic [NODES-1:0] adj_rdata;
  logic [NODES-1:0] adj_wdata;
  logic             adj_we;
  logic [NW-1:0]    stk_waddr;
  logic [NW-1:0]    stk_raddr;
  logic [SW-1:0]    stk_wdata;
  logic [SW-1:0]    stk_rdata;
  logic             stk_we;

  // decoded helpers
  logic [NW-1:0]    from_idx;
  logic [NW-1:0]    to_idx;
  logic [NW-1:0]    v_idx;
  logic [NW-1:0]    root_idx;
  logic             in_range;
  logic [NODES-1:0] row;
  logic [NODES-1:0] to_mask;

  assign from_idx = NW'(req_q.from_node);
  assign to_idx   = NW'(req_q.to_node);
  assign v_idx    = cur_v_q[NW-1:0];
  assign root_idx = root_q[NW-1:0];
  assign in_range = (32'(req_q.from_node) < NODES) && (32'(req_q.to_node) < NODES);

  // rows never written read as empty
  assign row = rvalid_q ? adj_rdata : '0;

  // one-hot mask of the written target
  always_comb begin
    to_mask         = '0;
    to_mask[to_idx] = 1'b1;
  end

  // adjacency memory
  assign adj_raddr = cmd_i.adj_sel_from ? from_idx : cur_u_q;
  assign adj_we    = (cmd_i.op == OP_ADJ_WRITE) && in_range;
  assign adj_wdata = req_q.edge_present ? (row | to_mask) : (row & ~to_mask);

  gcdd_ram #(
    .WIDTH (NODES),
    .DEPTH (NODES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (from_idx),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  // path stack memory, current top node lives in registers
  assign stk_we    = (cmd_i.op == OP_PUSH);
  assign stk_waddr = NW'(depth_q - VW'(1));
  assign stk_raddr = NW'(depth_q - VW'(2));
  assign stk_wdata = {cur_u_q, cur_v_q + VW'(1)};

  gcdd_ram #(
    .WIDTH (SW),
    .DEPTH (NODES)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // status toward the controller
  always_comb begin
    status_o.root_end     = (root_q == VW'(NODES));
    status_o.root_visited = on_path_q[root_idx] | done_q[root_idx];
    status_o.v_end        = (cur_v_q == VW'(NODES));
    status_o.edge_hit     = row[v_idx] && (v_idx != cur_u_q);
    status_o.v_on_path    = on_path_q[v_idx];
    status_o.v_unvisited  = !on_path_q[v_idx] && !done_q[v_idx];
    status_o.depth_full   = (depth_q == VW'(NODES));
    status_o.depth_one    = (depth_q == VW'(1));
  end

  // next-state for the datapath registers
  always_comb begin
    req_d       = req_q;
    cur_u_d     = cur_u_q;
    cur_v_d     = cur_v_q;
    depth_d     = depth_q;
    root_d      = root_q;
    on_path_d   = on_path_q;
    done_d      = done_q;
    row_valid_d = row_valid_q;
    found_d     = found_q;
    bf_d        = bf_q;
    bt_d        = bt_q;
    unique case (cmd_i.op)
      OP_LATCH: begin
        req_d     = req_i;
        on_path_d = '0;
        done_d    = '0;
        root_d    = '0;
        depth_d   = '0;
        found_d   = 1'b0;
        bf_d      = '0;
        bt_d      = '0;
      end
      OP_ADJ_WRITE: begin
        if (in_range) begin
          row_valid_d[from_idx] = 1'b1;
        end
      end
      OP_ROOT_NEXT: begin
        root_d = root_q + VW'(1);
      end
      OP_ROOT_ENTER: begin
        cur_u_d             = root_idx;
        cur_v_d             = '0;
        depth_d             = VW'(1);
        on_path_d[root_idx] = 1'b1;
      end
      OP_SKIP: begin
        cur_v_d = cur_v_q + VW'(1);
      end
      OP_PUSH: begin
        cur_u_d          = v_idx;
        cur_v_d          = '0;
        depth_d          = depth_q + VW'(1);
        on_path_d[v_idx] = 1'b1;
      end
      OP_POP: begin
        on_path_d[cur_u_q] = 1'b0;
        done_d[cur_u_q]    = 1'b1;
        depth_d            = depth_q - VW'(1);
      end
      OP_RESTORE: begin
        cur_u_d = stk_rdata[SW-1:VW];
        cur_v_d = stk_rdata[VW-1:0];
      end
      OP_HIT: begin
        found_d = 1'b1;
        bf_d    = NODE_W'(cur_u_q);
        bt_d    = NODE_W'(v_idx);
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // payload latch
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  // search and graph state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_u_q     <= '0;
      cur_v_q     <= '0;
      depth_q     <= '0;
      root_q      <= '0;
      on_path_q   <= '0;
      done_q      <= '0;
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      bf_q        <= '0;
      bt_q        <= '0;
    end else begin
      cur_u_q     <= cur_u_d;
      cur_v_q     <= cur_v_d;
      depth_q     <= depth_d;
      root_q      <= root_d;
      on_path_q   <= on_path_d;
      done_q      <= done_d;
      row_valid_q <= row_valid_d;
      rvalid_q    <= row_valid_q[adj_raddr];
      found_q     <= found_d;
      bf_q        <= bf_d;
      bt_q        <= bt_d;
    end
  end

  // result beat
  assign res_o.cycle_found = found_q;
  assign res_o.back_from   = bf_q;
  assign res_o.back_to     = bt_q;

endmodule

### design/gcdd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcdd_ctrl: search sequencer
// Walks the edge update, root selection, neighbor scan, push and pop steps.
// ----------------------------------------------------------------------------
module gcdd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  gcdd_pkg::status_t status_i,
  output gcdd_pkg::cmd_t    cmd_o,
  output logic              busy,
  output logic              done_o
);
  import gcdd_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d            = state_q;
    cmd_o.op           = OP_NONE;
    cmd_o.adj_sel_from = 1'b0;
    busy               = 1'b1;
    done_o             = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.op = OP_LATCH;
          state_d  = ST_EDIT_RD;
        end
      end
      ST_EDIT_RD: begin
        cmd_o.adj_sel_from = 1'b1;
        state_d            = ST_EDIT_WR;
      end
      ST_EDIT_WR: begin
        cmd_o.adj_sel_from = 1'b1;
        cmd_o.op           = OP_ADJ_WRITE;
        state_d            = ST_ROOT;
      end
      ST_ROOT: begin
        priority if (status_i.root_end) begin
          state_d = ST_FINISH;
        end else if (status_i.root_visited) begin
          cmd_o.op = OP_ROOT_NEXT;
        end else begin
          cmd_o.op = OP_ROOT_ENTER;
          state_d  = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (status_i.v_end) begin
          cmd_o.op = OP_POP;
          state_d  = status_i.depth_one ? ST_ROOT : ST_POP_WAIT;
        end else if (!status_i.edge_hit) begin
          cmd_o.op = OP_SKIP;
        end else if (status_i.v_on_path) begin
          cmd_o.op = OP_HIT;
          state_d  = ST_FINISH;
        end else if (status_i.v_unvisited && !status_i.depth_full) begin
          cmd_o.op = OP_PUSH;
          state_d  = ST_FETCH;
        end else begin
          cmd_o.op = OP_SKIP;
        end
      end
      ST_POP_WAIT: begin
        cmd_o.op = OP_RESTORE;
        state_d  = ST_FETCH;
      end
      ST_FINISH: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/graph_cycle_deadlock_detector.sv
`timescale 1ns / 1ps
// a search runs from the accepted beat to the result beat; a new beat is taken only
//   once busy has dropped after the result beat
// throughput: one neighbor check per cycle while the controller is in the scan state
// reset: adjacency rows read as empty through per-row valid flags, no clear pass
// done_o marks the result for exactly one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
// graph_cycle_deadlock_detector: wait-for graph cycle detector
// Applies one edge write per beat, then runs a depth-first cycle search and
// reports the first back edge found.
// ----------------------------------------------------------------------------
module graph_cycle_deadlock_detector #(
  parameter int unsigned NODES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  gcdd_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output gcdd_pkg::res_t res_o
);
  import gcdd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  gcdd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // graph storage and search datapath
  gcdd_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .res_o    (res_o)
  );

endmodule
